/* design/cpp_pkg.sv */
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types, widths and constants of the camera point projection unit.
// ----------------------------------------------------------------------------
package cpp_pkg;

    // screen size in pixels
    localparam int SCREEN_WIDTH  = 1600;
    localparam int SCREEN_HEIGHT = 1200;

    // port widths
    localparam int CAM_W      = 32;
    localparam int QT_W       = 16;
    localparam int PT_W       = 32;
    localparam int RAD_W      = 31;
    localparam int SXY_W      = 20;
    localparam int SR_W       = 19;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int Q28_W  = 35;
    localparam int M_W    = 22;
    localparam int DIFF_W = 33;
    localparam int PROD_W = M_W + DIFF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int LOC_W  = ACC_W - 16;
    localparam int XS_W   = LOC_W + 1;
    localparam int YS_W   = LOC_W + 3;
    localparam int K_W    = 19;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 44;
    localparam int REM_W  = 64;

    // divider: one quotient bit per stage plus an overflow check stage
    localparam int DIV_BITS = SR_W;
    localparam int DIV_LAT  = DIV_BITS + 1;

    // pixel scale factors, Q.4 with the factor 2 of the half-up rounding folded in
    localparam logic signed [K_W-1:0] SX_K = K_W'(SCREEN_WIDTH * 8);
    localparam logic signed [K_W-1:0] SY_K = K_W'(SCREEN_HEIGHT * 8);
    localparam logic signed [K_W-1:0] SR_K = K_W'(SCREEN_WIDTH * 16);

    // queue between front and back
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = 3;
    localparam int FRONT_INFLIGHT = 3;

    // cycles for the rotation matrix to follow a register write
    localparam logic [1:0] SETTLE_CYC = 2'd2;

    localparam logic signed [QT_W-1:0] QUAT_W_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_QUAT_W = 3'd3,
        REG_QUAT_X = 3'd4,
        REG_QUAT_Y = 3'd5,
        REG_QUAT_Z = 3'd6
    } t_reg_idx;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEPTH = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic                  vld;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [LOC_W-1:0] lx;
        logic signed [LOC_W-1:0] ly;
        logic signed [LOC_W-1:0] lz;
        logic [RAD_W-1:0]        r;
    } t_loc;

endpackage

/* design/camera_point_projection_unit.sv */
// ----------------------------------------------------------------------------
// camera_point_projection_unit
// Accepts one point per cycle while busy is low; the result strobe follows after the front, the queue and the back.
// The rate is set by the fully pipelined front transform and the three
// 20-stage pipelined dividers in the back; the result receiver cannot stall.
// Reset restores the camera registers to defaults and empties the pipeline;
// busy stays high after reset and after each register write while the rotation matrix settles.
// ----------------------------------------------------------------------------
module camera_point_projection_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [cpp_pkg::PT_W-1:0]      i_point_x,
    input  logic signed [cpp_pkg::PT_W-1:0]      i_point_y,
    input  logic signed [cpp_pkg::PT_W-1:0]      i_point_z,
    input  logic [cpp_pkg::RAD_W-1:0]            i_radius,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cpp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_res_strobe,
    output logic signed [cpp_pkg::SXY_W-1:0]     o_screen_x,
    output logic signed [cpp_pkg::SXY_W-1:0]     o_screen_y,
    output logic [cpp_pkg::SR_W-1:0]             o_screen_radius,
    output logic [cpp_pkg::ST_W-1:0]             o_status
);

    cpp_pkg::t_cfg_wr w_cfg;
    cpp_pkg::t_loc    w_push_loc, w_head_loc;
    logic             w_settle, w_push, w_head_vld, w_near_full, w_acc;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.vld   = i_cfg_valid;
    assign w_cfg.idx   = i_cfg_idx;
    assign w_cfg.data  = i_cfg_data;

    assign busy  = w_settle || w_near_full;
    assign w_acc = start && !busy;

    cpp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_acc    (w_acc),
        .i_px     (i_point_x),
        .i_py     (i_point_y),
        .i_pz     (i_point_z),
        .i_rad    (i_radius),
        .o_settle (w_settle),
        .o_push   (w_push),
        .o_loc    (w_push_loc)
    );

    // the back never stalls, so pop whenever a beat waits
    cpp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_push_loc),
        .i_pop       (w_head_vld),
        .o_vld       (w_head_vld),
        .o_data      (w_head_loc),
        .o_near_full (w_near_full)
    );

    cpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_head_vld),
        .i_loc    (w_head_loc),
        .o_strobe (o_res_strobe),
        .o_sx     (o_screen_x),
        .o_sy     (o_screen_y),
        .o_sr     (o_screen_radius),
        .o_status (o_status)
    );

endmodule

/* design/cpp_front.sv */
// ----------------------------------------------------------------------------
// cpp_front
// Configuration registers, rotation matrix, and the camera-space transform.
// ----------------------------------------------------------------------------
module cpp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpp_pkg::t_cfg_wr                  i_cfg,
    input  logic                              i_acc,
    input  logic signed [cpp_pkg::PT_W-1:0]   i_px,
    input  logic signed [cpp_pkg::PT_W-1:0]   i_py,
    input  logic signed [cpp_pkg::PT_W-1:0]   i_pz,
    input  logic [cpp_pkg::RAD_W-1:0]         i_rad,
    output logic                              o_settle,
    output logic                              o_push,
    output cpp_pkg::t_loc                     o_loc
);

    logic signed [cpp_pkg::CAM_W-1:0] r_cam [0:2];
    logic signed [cpp_pkg::QT_W-1:0]  r_qw, r_qx, r_qy, r_qz;
    logic [1:0]                       r_settle;

    logic signed [2*cpp_pkg::QT_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz,
                                       r_wy, r_yz, r_wx;
    logic signed [cpp_pkg::M_W-1:0]    r_m [0:2][0:2];
    logic signed [cpp_pkg::M_W-1:0]    n_m [0:2][0:2];

    logic                               r_v1, r_v2;
    logic signed [cpp_pkg::DIFF_W-1:0]  r_d [0:2];
    logic [cpp_pkg::RAD_W-1:0]          r_r1, r_r2;
    logic signed [cpp_pkg::PROD_W-1:0]  r_p [0:2][0:2];
    logic signed [cpp_pkg::ACC_W-1:0]   n_acc [0:2];

    function automatic logic signed [cpp_pkg::M_W-1:0] to_m(
        input logic signed [cpp_pkg::Q28_W-1:0] v
    );
        logic signed [cpp_pkg::Q28_W-1:0] t;
        t = v + cpp_pkg::Q28_W'(2048);
        return t[cpp_pkg::M_W+11:12];
    endfunction

    function automatic logic signed [cpp_pkg::Q28_W-1:0] Q28_ext(
        input logic signed [2*cpp_pkg::QT_W-1:0] v
    );
        return cpp_pkg::Q28_W'(v);
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0] <= '0;
            r_cam[1] <= '0;
            r_cam[2] <= '0;
            r_qw     <= cpp_pkg::QUAT_W_RESET;
            r_qx     <= '0;
            r_qy     <= '0;
            r_qz     <= '0;
            r_settle <= cpp_pkg::SETTLE_CYC;
        end else if (i_cfg.vld) begin
            r_settle <= cpp_pkg::SETTLE_CYC;
            unique case (cpp_pkg::t_reg_idx'(i_cfg.idx))
                cpp_pkg::REG_CAM_X:  r_cam[0] <= i_cfg.data;
                cpp_pkg::REG_CAM_Y:  r_cam[1] <= i_cfg.data;
                cpp_pkg::REG_CAM_Z:  r_cam[2] <= i_cfg.data;
                cpp_pkg::REG_QUAT_W: r_qw     <= i_cfg.data[cpp_pkg::QT_W-1:0];
                cpp_pkg::REG_QUAT_X: r_qx     <= i_cfg.data[cpp_pkg::QT_W-1:0];
                cpp_pkg::REG_QUAT_Y: r_qy     <= i_cfg.data[cpp_pkg::QT_W-1:0];
                cpp_pkg::REG_QUAT_Z: r_qz     <= i_cfg.data[cpp_pkg::QT_W-1:0];
                default: ;
            endcase
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    assign o_settle = (r_settle != 2'd0);

    // quaternion products, then the matrix of the conjugate rotation
    always_ff @(posedge i_clk) begin
        r_ww <= r_qw * r_qw;
        r_xx <= r_qx * r_qx;
        r_yy <= r_qy * r_qy;
        r_zz <= r_qz * r_qz;
        r_xy <= r_qx * r_qy;
        r_wz <= r_qw * r_qz;
        r_xz <= r_qx * r_qz;
        r_wy <= r_qw * r_qy;
        r_yz <= r_qy * r_qz;
        r_wx <= r_qw * r_qx;
    end

    always_comb begin
        n_m[0][0] = to_m(Q28_ext(r_ww) + Q28_ext(r_xx) - Q28_ext(r_yy) - Q28_ext(r_zz));
        n_m[0][1] = to_m((Q28_ext(r_xy) + Q28_ext(r_wz)) <<< 1);
        n_m[0][2] = to_m((Q28_ext(r_xz) - Q28_ext(r_wy)) <<< 1);
        n_m[1][0] = to_m((Q28_ext(r_xy) - Q28_ext(r_wz)) <<< 1);
        n_m[1][1] = to_m(Q28_ext(r_ww) - Q28_ext(r_xx) + Q28_ext(r_yy) - Q28_ext(r_zz));
        n_m[1][2] = to_m((Q28_ext(r_yz) + Q28_ext(r_wx)) <<< 1);
        n_m[2][0] = to_m((Q28_ext(r_xz) + Q28_ext(r_wy)) <<< 1);
        n_m[2][1] = to_m((Q28_ext(r_yz) - Q28_ext(r_wx)) <<< 1);
        n_m[2][2] = to_m(Q28_ext(r_ww) - Q28_ext(r_xx) - Q28_ext(r_yy) + Q28_ext(r_zz));
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_m[i][j] <= n_m[i][j];
            end
        end
    end

    // transform pipeline: difference, products, sum and round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0] <= cpp_pkg::DIFF_W'(i_px) - cpp_pkg::DIFF_W'(r_cam[0]);
        r_d[1] <= cpp_pkg::DIFF_W'(i_py) - cpp_pkg::DIFF_W'(r_cam[1]);
        r_d[2] <= cpp_pkg::DIFF_W'(i_pz) - cpp_pkg::DIFF_W'(r_cam[2]);
        r_r1   <= i_rad;
        r_r2   <= r_r1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_p[i][j] <= cpp_pkg::PROD_W'(r_m[i][j]) * cpp_pkg::PROD_W'(r_d[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = cpp_pkg::ACC_W'(r_p[i][0]) + cpp_pkg::ACC_W'(r_p[i][1])
                     + cpp_pkg::ACC_W'(r_p[i][2]) + cpp_pkg::ACC_W'(32768);
        end
    end

    assign o_push   = r_v2;
    assign o_loc.lx = n_acc[0][cpp_pkg::ACC_W-1:16];
    assign o_loc.ly = n_acc[1][cpp_pkg::ACC_W-1:16];
    assign o_loc.lz = n_acc[2][cpp_pkg::ACC_W-1:16];
    assign o_loc.r  = r_r2;

endmodule

/* design/cpp_fifo.sv */
// ----------------------------------------------------------------------------
// cpp_fifo
// Short queue of camera-space points between the front and the back.
// ----------------------------------------------------------------------------
module cpp_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  cpp_pkg::t_loc                   i_data,
    input  logic                            i_pop,
    output logic                            o_vld,
    output cpp_pkg::t_loc                   o_data,
    output logic                            o_near_full
);

    cpp_pkg::t_loc                r_mem [0:cpp_pkg::FIFO_DEPTH-1];
    logic [cpp_pkg::FIFO_AW-1:0]  r_wr, r_rd;
    logic [cpp_pkg::FIFO_AW:0]    r_cnt;
    logic                         v_pop;

    assign v_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (v_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (cpp_pkg::FIFO_AW+1)'(i_push) - (cpp_pkg::FIFO_AW+1)'(v_pop);
        end
    end

    assign o_vld       = (r_cnt != '0);
    assign o_data      = r_mem[r_rd];
    // leave room for the points still inside the front
    assign o_near_full = (r_cnt >= (cpp_pkg::FIFO_AW+1)'(cpp_pkg::FIFO_DEPTH
                                                          - cpp_pkg::FRONT_INFLIGHT));

endmodule

/* design/cpp_div.sv */
// ----------------------------------------------------------------------------
// cpp_div
// Pipelined floor divider, one quotient bit per stage, with signed clamp.
// ----------------------------------------------------------------------------
module cpp_div (
    input  logic                               i_clk,
    input  logic [cpp_pkg::NUM_W-2:0]          i_num,
    input  logic                               i_neg,
    input  logic [cpp_pkg::DEN_W-1:0]          i_den,
    output logic signed [cpp_pkg::SXY_W-1:0]   o_q,
    output logic                               o_sat
);

    logic [cpp_pkg::REM_W-1:0]    r_rem [0:cpp_pkg::DIV_BITS];
    logic [cpp_pkg::DEN_W-1:0]    r_den [0:cpp_pkg::DIV_BITS];
    logic [cpp_pkg::DIV_BITS-1:0] r_q   [0:cpp_pkg::DIV_BITS];
    logic                         r_neg [0:cpp_pkg::DIV_BITS];
    logic                         r_ovf [0:cpp_pkg::DIV_BITS];

    logic [cpp_pkg::REM_W-1:0]    n_rem [1:cpp_pkg::DIV_BITS];
    logic [cpp_pkg::DIV_BITS-1:0] n_q   [1:cpp_pkg::DIV_BITS];
    logic [cpp_pkg::REM_W-1:0]    v_sub [1:cpp_pkg::DIV_BITS];

    // the quotient fits only when the numerator is below den << DIV_BITS
    always_ff @(posedge i_clk) begin
        r_rem[0] <= cpp_pkg::REM_W'(i_num);
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_neg[0] <= i_neg;
        r_ovf[0] <= cpp_pkg::REM_W'(i_num)
                    >= (cpp_pkg::REM_W'(i_den) << cpp_pkg::DIV_BITS);
    end

    always_comb begin
        for (int j = 1; j <= cpp_pkg::DIV_BITS; j++) begin
            v_sub[j] = cpp_pkg::REM_W'(r_den[j-1]) << (cpp_pkg::DIV_BITS - j);
            n_q[j]   = r_q[j-1];
            if (r_rem[j-1] >= v_sub[j]) begin
                n_rem[j]                      = r_rem[j-1] - v_sub[j];
                n_q[j][cpp_pkg::DIV_BITS - j] = 1'b1;
            end else begin
                n_rem[j] = r_rem[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 1; j <= cpp_pkg::DIV_BITS; j++) begin
            r_rem[j] <= n_rem[j];
            r_den[j] <= r_den[j-1];
            r_q[j]   <= n_q[j];
            r_neg[j] <= r_neg[j-1];
            r_ovf[j] <= r_ovf[j-1];
        end
    end

    // a negative numerator came in bit-inverted, so invert the quotient back
    always_comb begin
        o_sat = r_ovf[cpp_pkg::DIV_BITS];
        if (r_ovf[cpp_pkg::DIV_BITS]) begin
            o_q = r_neg[cpp_pkg::DIV_BITS] ? {1'b1, {(cpp_pkg::SXY_W-1){1'b0}}}
                                           : {1'b0, {(cpp_pkg::SXY_W-1){1'b1}}};
        end else if (r_neg[cpp_pkg::DIV_BITS]) begin
            o_q = ~{1'b0, r_q[cpp_pkg::DIV_BITS]};
        end else begin
            o_q = {1'b0, r_q[cpp_pkg::DIV_BITS]};
        end
    end

endmodule

/* design/cpp_back.sv */
// ----------------------------------------------------------------------------
// cpp_back
// Pixel mapping: scale, divide by depth, clamp and set the status.
// ----------------------------------------------------------------------------
module cpp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  cpp_pkg::t_loc                      i_loc,
    output logic                               o_strobe,
    output logic signed [cpp_pkg::SXY_W-1:0]   o_sx,
    output logic signed [cpp_pkg::SXY_W-1:0]   o_sy,
    output logic [cpp_pkg::SR_W-1:0]           o_sr,
    output logic [cpp_pkg::ST_W-1:0]           o_status
);

    logic                              r_v1, r_v2;
    logic                              r_np1, r_np2;
    logic signed [cpp_pkg::NUM_W-1:0]  r_nx, r_ny, r_nr, r_lz;
    logic signed [cpp_pkg::XS_W-1:0]   v_xs;
    logic signed [cpp_pkg::YS_W-1:0]   v_ys;
    logic signed [cpp_pkg::NUM_W-1:0]  v_ax, v_ay, v_ar, v_bx, v_by;

    logic [cpp_pkg::NUM_W-2:0]         r_ax, r_ay, r_ar;
    logic                              r_sx_neg, r_sy_neg, r_sr_neg;
    logic [cpp_pkg::DEN_W-1:0]         r_bx, r_by;

    logic                              r_vd  [0:cpp_pkg::DIV_LAT-1];
    logic                              r_npd [0:cpp_pkg::DIV_LAT-1];

    logic signed [cpp_pkg::SXY_W-1:0]  w_qx, w_qy, w_qr;
    logic                              w_satx, w_saty, w_satr;

    // stage 1: numerators before the rounding term
    always_comb begin
        v_xs = cpp_pkg::XS_W'(i_loc.lx) + cpp_pkg::XS_W'(i_loc.lz);
        v_ys = (cpp_pkg::YS_W'(i_loc.lz) <<< 1) + cpp_pkg::YS_W'(i_loc.lz)
             - (cpp_pkg::YS_W'(i_loc.ly) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        r_nx  <= cpp_pkg::NUM_W'(v_xs) * cpp_pkg::NUM_W'(cpp_pkg::SX_K);
        r_ny  <= cpp_pkg::NUM_W'(v_ys) * cpp_pkg::NUM_W'(cpp_pkg::SY_K);
        r_nr  <= cpp_pkg::NUM_W'($signed({1'b0, i_loc.r})) * cpp_pkg::NUM_W'(cpp_pkg::SR_K);
        r_lz  <= cpp_pkg::NUM_W'(i_loc.lz);
        r_np1 <= i_loc.lz[cpp_pkg::LOC_W-1] || (i_loc.lz == '0);
    end

    // stage 2: half-up rounding as floor((2n + d) / 2d); fold the sign for floor
    always_comb begin
        v_ax = (r_nx <<< 1) + r_lz;
        v_ay = (r_ny <<< 1) + (r_lz <<< 1) + r_lz;
        v_ar = (r_nr <<< 1) + r_lz;
        v_bx = r_lz <<< 1;
        v_by = (r_lz <<< 2) + (r_lz <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= v_ax[cpp_pkg::NUM_W-2:0] ^ {(cpp_pkg::NUM_W-1){v_ax[cpp_pkg::NUM_W-1]}};
        r_ay     <= v_ay[cpp_pkg::NUM_W-2:0] ^ {(cpp_pkg::NUM_W-1){v_ay[cpp_pkg::NUM_W-1]}};
        r_ar     <= v_ar[cpp_pkg::NUM_W-2:0] ^ {(cpp_pkg::NUM_W-1){v_ar[cpp_pkg::NUM_W-1]}};
        r_sx_neg <= v_ax[cpp_pkg::NUM_W-1];
        r_sy_neg <= v_ay[cpp_pkg::NUM_W-1];
        r_sr_neg <= v_ar[cpp_pkg::NUM_W-1];
        r_bx     <= v_bx[cpp_pkg::DEN_W-1:0];
        r_by     <= v_by[cpp_pkg::DEN_W-1:0];
        r_np2    <= r_np1;
    end

    cpp_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_ax),
        .i_neg (r_sx_neg),
        .i_den (r_bx),
        .o_q   (w_qx),
        .o_sat (w_satx)
    );

    cpp_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_ay),
        .i_neg (r_sy_neg),
        .i_den (r_by),
        .o_q   (w_qy),
        .o_sat (w_saty)
    );

    cpp_div u_div_r (
        .i_clk (i_clk),
        .i_num (r_ar),
        .i_neg (r_sr_neg),
        .i_den (r_bx),
        .o_q   (w_qr),
        .o_sat (w_satr)
    );

    // track beats alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            o_strobe <= 1'b0;
            for (int k = 0; k < cpp_pkg::DIV_LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else begin
            r_v1     <= i_vld;
            r_v2     <= r_v1;
            r_vd[0]  <= r_v2;
            for (int k = 1; k < cpp_pkg::DIV_LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            o_strobe <= r_vd[cpp_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_npd[0] <= r_np2;
        for (int k = 1; k < cpp_pkg::DIV_LAT; k++) begin
            r_npd[k] <= r_npd[k-1];
        end
    end

    // output register; depth not positive forces zeros
    always_ff @(posedge i_clk) begin
        if (r_npd[cpp_pkg::DIV_LAT-1]) begin
            o_sx     <= '0;
            o_sy     <= '0;
            o_sr     <= '0;
            o_status <= cpp_pkg::ST_DEPTH;
        end else begin
            o_sx     <= w_qx;
            o_sy     <= w_qy;
            o_sr     <= w_qr[cpp_pkg::SR_W-1:0];
            o_status <= (w_satx || w_saty || w_satr) ? cpp_pkg::ST_SAT : cpp_pkg::ST_OK;
        end
    end

endmodule
